// ===== hw/rtl/hswo_pkg.sv =====
// ----------------------------------------------------------------------------
// hswo_pkg
// Shared types and request codes for the hard-synced wavetable oscillator.
// ----------------------------------------------------------------------------
package hswo_pkg;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_WR_ONE = 2'd1;
	localparam logic [1:0] REQ_WR_TWO = 2'd2;

	// Fixed field widths.
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned INDEX_W  = 9;
	localparam int unsigned SAMPLE_W = 8;

	// One input item.
	typedef struct packed {
		logic [1:0]          req_type;
		logic [PHASE_W-1:0]  main_step;
		logic [PHASE_W-1:0]  sync_step;
		logic [INDEX_W-1:0]  table_index;
		logic [SAMPLE_W-1:0] table_byte;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
		logic                sub_osc;
	} rsp_t;

endpackage

// ===== hw/rtl/hswo_ram.sv =====
// ----------------------------------------------------------------------------
// hswo_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module hswo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/hard_sync_wavetable_oscillator.sv =====
// An accepted tick goes through stage 1 (table read) and then the output register to rsp, waiting while rsp stalls.
// Throughput: one item per cycle while req_stall is low; the two table memories are read once per tick.
// Table writes give no result.
// Reset clears both phases, the held sample, the sub-oscillator level and all
// valid flags; table contents are undefined until written.
// ----------------------------------------------------------------------------
// hard_sync_wavetable_oscillator
// Direct digital synthesis oscillator with hard sync. Phase accumulators
// address two half-wave tables in memory; their summed bytes form the sample
// that the next tick emits. TABLE_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module hard_sync_wavetable_oscillator #(
	parameter int TABLE_SIZE = 512,
	parameter int FRAC_BITS  = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  hswo_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hswo_pkg::rsp_t rsp
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int PW = hswo_pkg::PHASE_W - FRAC_BITS;
	localparam logic [31:0] MIRROR_TOP = 32'(2 * TABLE_SIZE - 1);

	// Architectural state.
	logic [hswo_pkg::PHASE_W-1:0]  main_phase_q;
	logic [hswo_pkg::PHASE_W-1:0]  sync_phase_q;
	logic [hswo_pkg::SAMPLE_W-1:0] held_q;
	logic                          sub_level_q;

	// Stage 1: table read in flight.
	logic s1_valid_q;
	logic half_s1;
	logic sub_s1;

	// Output register.
	logic           rsp_valid_q;
	hswo_pkg::rsp_t rsp_q;

	logic req_acc;
	logic tick_acc;
	logic s1_adv;

	logic [hswo_pkg::PHASE_W:0]    sync_sum;
	logic                          sync_wrap;
	logic [hswo_pkg::PHASE_W-1:0]  main_next;
	logic [PW-1:0]                 pos;
	logic [31:0]                   pos32;
	logic [31:0]                   mirror32;
	logic                          first_half;
	logic [AW-1:0]                 raddr;
	logic [31:0]                   widx32;
	logic                          widx_ok;
	logic                          we_one;
	logic                          we_two;
	logic [hswo_pkg::SAMPLE_W-1:0] rd_one;
	logic [hswo_pkg::SAMPLE_W-1:0] rd_two;
	logic [hswo_pkg::SAMPLE_W-1:0] tab_sum;
	logic [hswo_pkg::SAMPLE_W-1:0] held_next;

	// Handshake: stage 1 moves on when the output register is free or drains.
	assign s1_adv    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && rsp_valid_q && rsp_stall;
	assign req_acc   = req_valid && !req_stall;
	assign tick_acc  = req_acc && (req.req_type == hswo_pkg::REQ_TICK);

	// Phase advance with hard sync on a sync phase wrap.
	assign sync_sum  = {1'b0, sync_phase_q} + {1'b0, req.sync_step};
	assign sync_wrap = sync_sum[hswo_pkg::PHASE_W];
	assign main_next = sync_wrap ? '0 : main_phase_q + req.main_step;

	// Table address: forward over the first half, mirrored over the second.
	assign pos        = main_next[hswo_pkg::PHASE_W-1:FRAC_BITS];
	assign pos32      = 32'(pos);
	assign first_half = pos32 < 32'(TABLE_SIZE);
	assign mirror32   = MIRROR_TOP - pos32;
	assign raddr      = first_half ? pos32[AW-1:0] : mirror32[AW-1:0];

	// Table writes outside the table are dropped.
	assign widx32  = 32'(req.table_index);
	assign widx_ok = widx32 < 32'(TABLE_SIZE);
	assign we_one  = req_acc && widx_ok && (req.req_type == hswo_pkg::REQ_WR_ONE);
	assign we_two  = req_acc && widx_ok && (req.req_type == hswo_pkg::REQ_WR_TWO);

	hswo_ram #(
		.WIDTH(hswo_pkg::SAMPLE_W),
		.DEPTH(TABLE_SIZE)
	) u_table_one (
		.clk   (clk),
		.we    (we_one),
		.waddr (widx32[AW-1:0]),
		.wdata (req.table_byte),
		.re    (tick_acc),
		.raddr (raddr),
		.rdata (rd_one)
	);

	hswo_ram #(
		.WIDTH(hswo_pkg::SAMPLE_W),
		.DEPTH(TABLE_SIZE)
	) u_table_two (
		.clk   (clk),
		.we    (we_two),
		.waddr (widx32[AW-1:0]),
		.wdata (req.table_byte),
		.re    (tick_acc),
		.raddr (raddr),
		.rdata (rd_two)
	);

	// Sum the two table bytes; negate over the first half.
	assign tab_sum   = rd_one + rd_two;
	assign held_next = half_s1 ? 8'(8'd0 - tab_sum) : tab_sum;

	// Phase and sub-oscillator state advance on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_phase_q <= '0;
			sync_phase_q <= '0;
			sub_level_q  <= 1'b0;
		end else if (tick_acc) begin
			main_phase_q <= main_next;
			sync_phase_q <= sync_sum[hswo_pkg::PHASE_W-1:0];
			sub_level_q  <= sub_level_q ^ sync_wrap;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tick_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			half_s1 <= first_half;
			sub_s1  <= sub_level_q ^ sync_wrap;
		end
	end

	// The item leaving stage 1 emits the previous sample and stores its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				held_q      <= held_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.sample_out <= held_q;
			rsp_q.sub_osc    <= sub_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// An accepted tick always lands in stage 1.
	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> s1_valid_q)
		else $error("accepted tick did not reach stage 1");

	// A stage 1 item that cannot move on is kept.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> s1_valid_q)
		else $error("stage 1 item lost while stalled");

	// Input is only stalled when both stages are full and the output is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (s1_valid_q && rsp_valid_q && rsp_stall))
		else $error("input stalled without a full pipeline");

	// A sync wrap resets the main phase.
	a_hard_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && sync_wrap) |=> (main_phase_q == '0))
		else $error("main phase not reset on sync wrap");
`endif

endmodule
